// ----- rtl/core/cubed_sine_tone_generator_defines.svh -----
// ============================================================================
// Assertion macros for the cubed sine tone generator
// Clocked on clk_i and held off while rst_ni is low.
// ============================================================================
`ifndef CUBED_SINE_TONE_GENERATOR_DEFINES_SVH
`define CUBED_SINE_TONE_GENERATOR_DEFINES_SVH

// Same-cycle implication
`define CTSG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ctsg assertion failed");

// Next-cycle implication
`define CTSG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ctsg assertion failed");

`endif

// ----- rtl/core/ctsg_pkg.sv -----
// ============================================================================
// ctsg_pkg
// Types, constants and the sine table builder shared by the tone generator.
// ============================================================================
package ctsg_pkg;

  // Field and register widths
  localparam int STEP_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int AMP_W    = 15;
  localparam int NOTE_W   = 21;
  localparam int SINE_W   = 15;  // magnitude of a table entry
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = NOTE_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_SAMPLES = 2'd1;

  // Register reset values
  localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd32760;
  localparam logic [NOTE_W-1:0] NOTE_RESET = 21'd8820;

  // Q15 rounding
  localparam int FRAC_BITS = 15;
  localparam logic [32:0] ROUND_HALF = 33'd16384;

  // Saturation limits of the output word
  localparam logic [16:0] POS_LIMIT = 17'd32767;
  localparam logic [16:0] NEG_LIMIT = 17'd32768;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // pi in Q30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK1,
    ST_SQ,
    ST_CUBE,
    ST_SUM,
    ST_AMP
  } ctsg_state_e;

  // Truncating quotient by restoring long division (shift, compare, subtract)
  function automatic logic [63:0] series_div(input logic [63:0] num,
                                             input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave entry: round(32767 * sin(pi/2 * (2i+1) / (2*depth))) by a
  // Q30 Taylor series; the depth is 2**log2d. Evaluated at elaboration.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                   input int unsigned log2d);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        v;
    logic               neg;
    x    = (PI_Q30 * (64'(idx) * 64'd2 + 64'd1)) >> (log2d + 2);
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    neg  = 1'b1;
    for (int k = 1; k < 40; k++) begin
      term = (term * x2) >> 30;
      term = series_div(term, 64'(2 * k) * 64'(2 * k + 1));
      if (neg) acc = acc - $signed(term);
      else     acc = acc + $signed(term);
      neg = !neg;
    end
    if (acc < 0) acc = 64'sd0;
    v = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return v[SINE_W-1:0];
  endfunction

endpackage

// ----- rtl/core/ctsg_sine_lut.sv -----
// ============================================================================
// ctsg_sine_lut
// Full-wave signed Q15 sine from a phase word, using a quarter-wave table.
// ============================================================================
module ctsg_sine_lut #(
  parameter int PHASE_BITS  = 32,
  parameter int TABLE_DEPTH = 256
) (
  input  logic [PHASE_BITS-1:0]              phase_i,
  output logic signed [ctsg_pkg::SAMPLE_W-1:0] value_o
);
  import ctsg_pkg::*;

  localparam int LOG2D = $clog2(TABLE_DEPTH);

  logic [SINE_W-1:0] table_w [TABLE_DEPTH];
  logic [LOG2D-1:0]  idx_raw;
  logic [LOG2D-1:0]  idx;
  logic [SINE_W-1:0] mag;

  // Build the constant quarter-wave table
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_entry
    localparam logic [SINE_W-1:0] Entry = sine_entry(i, LOG2D);
    assign table_w[i] = Entry;
  end

  // Mirror in odd quadrants, negate in the second half turn
  always_comb begin
    idx_raw = phase_i[PHASE_BITS-3 -: LOG2D];
    idx     = phase_i[PHASE_BITS-2] ? ~idx_raw : idx_raw;
    mag     = table_w[idx];
    value_o = phase_i[PHASE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

// ----- rtl/core/ctsg_round_mul.sv -----
// ============================================================================
// ctsg_round_mul
// Shared unsigned multiplier with Q15 round-half-up scaling.
// ============================================================================
module ctsg_round_mul (
  input  logic [16:0]                 a_i,
  input  logic [ctsg_pkg::AMP_W-1:0]  b_i,
  output logic [16:0]                 prod_o
);
  import ctsg_pkg::*;

  logic [32:0] full;

  // Multiply, round and drop the fraction
  always_comb begin
    full   = 33'(a_i) * 33'(b_i) + ROUND_HALF;
    prod_o = full[FRAC_BITS +: 17];
  end

endmodule

// ----- rtl/core/cubed_sine_tone_generator.sv -----
// ============================================================================
// cubed_sine_tone_generator
// Phase-accumulating tone oscillator giving amplitude*(sin^3 p + sin(p+2pi/3)).
// ============================================================================
// Each accepted word is one sample tick carrying a phase step (a full turn is
// 2^PHASE_BITS). The sample is computed from the current phase, then the phase
// advances by the step; on the last sample of a note (note_samples samples per
// note, 0 taken as 1) the phase and the sample count clear instead. A word
// passes from acceptance back to the point where a word can be taken through
// a lookup step, then four steps that reuse one sine table port and one
// 17x15 rounding multiplier (square, cube, sum, amplitude scale). The result
// sits in an output register, so a new word is taken while it waits; if the
// previous result has not been taken, the final step holds until it is.
// Configuration writes are accepted any cycle and take effect at once; the
// table depth must be a power of two.
module cubed_sine_tone_generator #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 32,
  parameter int NOTE_COUNT_BITS  = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ctsg_pkg::STEP_W-1:0]        phase_step_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ctsg_pkg::SAMPLE_W-1:0] sample_o,
  output logic                               last_of_note_o,
  input  logic                               cfg_we_i,
  input  logic [ctsg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ctsg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ctsg_pkg::*;

  localparam int CW = (NOTE_COUNT_BITS + 1 > NOTE_W) ? NOTE_COUNT_BITS + 1 : NOTE_W;
  localparam logic [PHASE_BITS-1:0] ThirdTurn =
    PHASE_BITS'(((65'd1 << PHASE_BITS) + 65'd1) / 65'd3);
  localparam logic [CW-1:0] NoteMax = CW'(1) << NOTE_COUNT_BITS;

  ctsg_state_e state_q, state_d;

  logic [AMP_W-1:0]           amplitude_q;
  logic [NOTE_W-1:0]          note_samples_q;
  logic [PHASE_BITS-1:0]      phase_q, phase_d;
  logic [NOTE_COUNT_BITS-1:0] index_q, index_d;
  logic                       out_valid_q, out_valid_d;

  logic [PHASE_BITS-1:0]      step_q;
  logic [SINE_W-1:0]          m1_q;
  logic                       s1_neg_q;
  logic signed [SAMPLE_W-1:0] s2_q;
  logic [SINE_W-1:0]          sq_q;
  logic [SINE_W-1:0]          cube_q;
  logic [16:0]                ms_q;
  logic                       sum_neg_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;

  logic                       accept;
  logic                       commit;
  logic [PHASE_BITS-1:0]      lut_phase;
  logic signed [SAMPLE_W-1:0] lut_val;
  logic [16:0]                mul_a;
  logic [AMP_W-1:0]           mul_b;
  logic [16:0]                mul_res;
  logic signed [17:0]         sum_w;
  logic [17:0]                sum_mag;
  logic signed [SAMPLE_W-1:0] sat_w;
  logic [CW-1:0]              count_inc;
  logic [CW-1:0]              ns_eff;
  logic                       last_w;

  // Shared sine lookup and multiplier
  ctsg_sine_lut #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_lut (
    .phase_i(lut_phase),
    .value_o(lut_val)
  );

  ctsg_round_mul u_mul (
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(mul_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LOOK1;
      ST_LOOK1: state_d = ST_SQ;
      ST_SQ:    state_d = ST_CUBE;
      ST_CUBE:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_AMP;
      ST_AMP:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, operand steering
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    lut_phase  = phase_q;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_LOOK1: lut_phase = phase_q;
      ST_SQ: begin
        lut_phase = phase_q + ThirdTurn;
        mul_a     = {2'b00, m1_q};
        mul_b     = m1_q;
      end
      ST_CUBE: begin
        mul_a = {2'b00, m1_q};
        mul_b = sq_q;
      end
      ST_SUM:   ;
      ST_AMP: begin
        mul_a  = ms_q;
        mul_b  = amplitude_q;
        commit = !out_valid_q || out_ready_i;
      end
      default:  ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // Sum of cube and shifted sine, then its magnitude
  always_comb begin
    sum_w   = (s1_neg_q ? -$signed({3'b000, cube_q}) : $signed({3'b000, cube_q}))
              + $signed({{2{s2_q[SAMPLE_W-1]}}, s2_q});
    sum_mag = sum_w[17] ? 18'(-sum_w) : 18'(sum_w);
  end

  // Saturate the scaled magnitude into the output word
  always_comb begin
    if (!sum_neg_q) begin
      sat_w = (mul_res > POS_LIMIT) ? SAMPLE_MAX : $signed(mul_res[SAMPLE_W-1:0]);
    end else begin
      sat_w = (mul_res > NEG_LIMIT) ? SAMPLE_MIN : -$signed(mul_res[SAMPLE_W-1:0]);
    end
  end

  // Note end: clip the length to [1, 2^NOTE_COUNT_BITS]
  always_comb begin
    count_inc = CW'(index_q) + CW'(1);
    ns_eff    = CW'(note_samples_q);
    if (ns_eff == '0) ns_eff = CW'(1);
    else if (ns_eff > NoteMax) ns_eff = NoteMax;
    last_w    = count_inc >= ns_eff;
  end

  // Advance or clear phase and count, track output occupancy
  always_comb begin
    phase_d     = phase_q;
    index_d     = index_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (commit) begin
      out_valid_d = 1'b1;
      if (last_w) begin
        phase_d = '0;
        index_d = '0;
      end else begin
        phase_d = phase_q + step_q;
        index_d = index_q + NOTE_COUNT_BITS'(1);
      end
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      amplitude_q    <= AMP_RESET;
      note_samples_q <= NOTE_RESET;
      phase_q        <= '0;
      index_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      index_q     <= index_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_AMPLITUDE) amplitude_q <= cfg_data_i[AMP_W-1:0];
        else if (cfg_idx_i == CFG_NOTE_SAMPLES) note_samples_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) step_q <= PHASE_BITS'(phase_step_i);
    if (state_q == ST_LOOK1) begin
      m1_q     <= lut_val[SAMPLE_W-1] ? SINE_W'(-lut_val) : SINE_W'(lut_val);
      s1_neg_q <= lut_val[SAMPLE_W-1];
    end
    if (state_q == ST_SQ) begin
      sq_q <= mul_res[SINE_W-1:0];
      s2_q <= lut_val;
    end
    if (state_q == ST_CUBE) cube_q <= mul_res[SINE_W-1:0];
    if (state_q == ST_SUM) begin
      ms_q      <= sum_mag[16:0];
      sum_neg_q <= sum_w[17];
    end
    if (commit) begin
      sample_q <= sat_w;
      last_q   <= last_w;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign last_of_note_o = last_q;

endmodule

// ----- rtl/core/ctsg_checker.sv -----
// ============================================================================
// ctsg_checker
// Port-level checks on the tone generator's sequencing and output handoff.
// ============================================================================
`include "cubed_sine_tone_generator_defines.svh"

module ctsg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] sample_o,
  input logic        last_of_note_o
);

  // A waiting word holds its value and flag
  `CTSG_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(sample_o) && $stable(last_of_note_o))

  // One word at a time: busy right after taking a word
  `CTSG_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // The result cannot appear the cycle after a word is taken
  `CTSG_ASSERT_NXT(a_no_early_result, in_valid_i && in_ready_o, !$rose(out_valid_o))

  // Returning to ready always delivers a result
  `CTSG_ASSERT_IMP(a_ready_with_result, $rose(in_ready_o), out_valid_o)

endmodule

bind cubed_sine_tone_generator ctsg_checker u_ctsg_checker (.*);
